[rtl/mvsf_pkg.sv]
package mvsf_pkg;

    localparam int OFFSET_W = 16;
    localparam int VALUE_W  = 32;
    localparam int WIDE_W   = 33;
    localparam int CMP_W    = 34;
    localparam int DIFF_W   = 35;
    localparam int DIV_BITS = 33;
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 56;
    localparam int CFG_IDX_W = 3;

    localparam logic [2:0] OP_LT  = 3'd0;
    localparam logic [2:0] OP_GT  = 3'd1;
    localparam logic [2:0] OP_LE  = 3'd2;
    localparam logic [2:0] OP_GE  = 3'd3;
    localparam logic [2:0] OP_EQ  = 3'd4;
    localparam logic [2:0] OP_NE  = 3'd5;
    localparam logic [2:0] OP_DIF = 3'd6;
    localparam logic [2:0] OP_MOD = 3'd7;

    localparam logic [1:0] SRC_PREV  = 2'd0;
    localparam logic [1:0] SRC_FIXED = 2'd1;
    localparam logic [1:0] SRC_ADDR  = 2'd2;
    localparam logic [1:0] SRC_COUNT = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [1:0] DISP_SIGNED = 2'd0;

    localparam logic [CFG_IDX_W-1:0] REG_OP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CVAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_N      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_X      = 3'd6;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        src;
        logic [1:0]        size;
        logic [1:0]        disp;
        logic [WIDE_W-1:0] cval;
        logic [WIDE_W-1:0] pn;
        logic [WIDE_W-1:0] px;
    } mvsf_cfg_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [VALUE_W-1:0]  current;
        logic                keep_cmp;
        logic                sl;
        logic                sn;
        logic [WIDE_W-1:0]   dvd;
        logic [WIDE_W-1:0]   rem;
        logic [WIDE_W-1:0]   dvs;
    } mvsf_div_t;

    function automatic logic signed [CMP_W-1:0] conv_value(
        input logic [VALUE_W-1:0] raw,
        input logic [1:0]         size,
        input logic               sgn
    );
        logic signed [CMP_W-1:0] r;
        if (size == SIZE_BYTE) begin
            r = {{(CMP_W-8){sgn & raw[7]}}, raw[7:0]};
        end else if (size == SIZE_HALF) begin
            r = {{(CMP_W-16){sgn & raw[15]}}, raw[15:0]};
        end else begin
            r = {{(CMP_W-32){sgn & raw[31]}}, raw[31:0]};
        end
        return r;
    endfunction

endpackage

[rtl/mvsf_front.sv]
module mvsf_front
    import mvsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  mvsf_cfg_t           cfg,
    input  logic                in_valid,
    input  logic [S_DATA_W-1:0] in_data,
    output logic                out_valid,
    output mvsf_div_t           out_item
);

    logic                    a_valid_reg;
    logic [OFFSET_W-1:0]     a_off_reg;
    logic [VALUE_W-1:0]      a_cur_reg;
    logic signed [CMP_W-1:0] a_lhs_reg;
    logic signed [CMP_W-1:0] a_rhs_reg;
    logic signed [CMP_W-1:0] lhs_next;
    logic signed [CMP_W-1:0] rhs_next;
    logic                    sgn;

    logic                     b_valid_reg;
    mvsf_div_t                b_item_reg;
    mvsf_div_t                b_item_next;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] n_ext;
    logic signed [CMP_W-1:0]  n_cmp;
    logic [CMP_W-1:0]         abs_l;
    logic [CMP_W-1:0]         abs_n;
    logic                     keep_c;

    assign sgn = (cfg.disp == DISP_SIGNED);

    always_comb begin
        if (cfg.src == SRC_COUNT) begin
            lhs_next = {2'b00, in_data[111:80]};
        end else begin
            lhs_next = conv_value(in_data[47:16], cfg.size, sgn);
        end
        unique case (cfg.src)
            SRC_PREV:  rhs_next = conv_value(in_data[79:48], cfg.size, sgn);
            SRC_ADDR:  rhs_next = conv_value(in_data[143:112], cfg.size, sgn);
            SRC_FIXED: rhs_next = {cfg.cval[WIDE_W-1], cfg.cval};
            SRC_COUNT: rhs_next = {cfg.cval[WIDE_W-1], cfg.cval};
            default:   rhs_next = {cfg.cval[WIDE_W-1], cfg.cval};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
        end
        if (adv) begin
            a_off_reg <= in_data[15:0];
            a_cur_reg <= in_data[47:16];
            a_lhs_reg <= lhs_next;
            a_rhs_reg <= rhs_next;
        end
    end

    always_comb begin
        n_cmp = {cfg.pn[WIDE_W-1], cfg.pn};
        n_ext = {{2{cfg.pn[WIDE_W-1]}}, cfg.pn};
        diff  = DIFF_W'(a_lhs_reg) - DIFF_W'(a_rhs_reg);
        abs_l = a_lhs_reg[CMP_W-1] ? CMP_W'(-a_lhs_reg) : a_lhs_reg;
        abs_n = n_cmp[CMP_W-1] ? CMP_W'(-n_cmp) : n_cmp;
        unique case (cfg.op)
            OP_LT:   keep_c = a_lhs_reg < a_rhs_reg;
            OP_GT:   keep_c = a_lhs_reg > a_rhs_reg;
            OP_LE:   keep_c = a_lhs_reg <= a_rhs_reg;
            OP_GE:   keep_c = a_lhs_reg >= a_rhs_reg;
            OP_EQ:   keep_c = a_lhs_reg == a_rhs_reg;
            OP_NE:   keep_c = a_lhs_reg != a_rhs_reg;
            OP_DIF:  keep_c = (diff == n_ext) || (-diff == n_ext);
            default: keep_c = 1'b0;
        endcase
        b_item_next.offset   = a_off_reg;
        b_item_next.current  = a_cur_reg;
        b_item_next.keep_cmp = keep_c;
        b_item_next.sl       = a_lhs_reg[CMP_W-1];
        b_item_next.sn       = cfg.pn[WIDE_W-1];
        b_item_next.dvd      = abs_l[WIDE_W-1:0];
        b_item_next.rem      = '0;
        b_item_next.dvs      = abs_n[WIDE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
        if (adv) begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

[rtl/mvsf_div_step.sv]
module mvsf_div_step
    import mvsf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic      in_valid,
    input  mvsf_div_t in_item,
    output logic      out_valid,
    output mvsf_div_t out_item
);

    logic            valid_reg;
    mvsf_div_t       item_reg;
    mvsf_div_t       item_next;
    logic [WIDE_W:0] trial;
    logic [WIDE_W:0] sub;
    logic            ge;

    always_comb begin
        trial = {in_item.rem, in_item.dvd[WIDE_W-1]};
        sub   = trial - {1'b0, in_item.dvs};
        ge    = trial >= {1'b0, in_item.dvs};
        item_next     = in_item;
        item_next.rem = ge ? sub[WIDE_W-1:0] : trial[WIDE_W-1:0];
        item_next.dvd = {in_item.dvd[WIDE_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/mvsf_back.sv]
module mvsf_back
    import mvsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  mvsf_cfg_t           cfg,
    input  logic                in_valid,
    input  mvsf_div_t           in_item,
    output logic                out_valid,
    output logic [M_DATA_W-1:0] out_data
);

    logic                    valid_reg;
    logic [OFFSET_W-1:0]     off_reg;
    logic                    keep_reg;
    logic [VALUE_W-1:0]      prev_reg;
    logic                    keep_next;
    logic [CMP_W-1:0]        mag;
    logic signed [CMP_W-1:0] r;
    logic signed [CMP_W-1:0] x_ext;

    always_comb begin
        x_ext = {cfg.px[WIDE_W-1], cfg.px};
        if (in_item.sl == in_item.sn) begin
            mag = {1'b0, in_item.rem};
        end else begin
            mag = {1'b0, in_item.dvs} - {1'b0, in_item.rem};
        end
        if (in_item.rem == '0) begin
            r = '0;
        end else if (in_item.sn) begin
            r = -mag;
        end else begin
            r = mag;
        end
        if (cfg.op == OP_MOD) begin
            keep_next = (cfg.pn != '0) && (r == x_ext);
        end else begin
            keep_next = in_item.keep_cmp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            off_reg  <= in_item.offset;
            keep_reg <= keep_next;
            prev_reg <= in_item.current;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {{(M_DATA_W-OFFSET_W-1-VALUE_W){1'b0}}, prev_reg, keep_reg, off_reg};

endmodule

[rtl/memory_value_search_filter.sv]
// Pipeline: 36 register stages from input request to result (2 front
// stages, 33 remainder stages, 1 output stage).
// Throughput: one request per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous, active low; clears all valid bits and loads the
// configuration registers with their defaults.
module memory_value_search_filter
    import mvsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_offset, current_value, previous_value, change_count, address_value
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_offset, keep, new_previous, zero pad
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [WIDE_W-1:0]    cfg_wdata
);

    mvsf_cfg_t cfg_reg;
    logic      adv;
    logic      v   [0:DIV_BITS];
    mvsf_div_t itm [0:DIV_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.op   <= OP_NE;
            cfg_reg.src  <= SRC_PREV;
            cfg_reg.size <= SIZE_BYTE;
            cfg_reg.disp <= DISP_SIGNED;
            cfg_reg.cval <= '0;
            cfg_reg.pn   <= '0;
            cfg_reg.px   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_OP:     cfg_reg.op   <= cfg_wdata[2:0];
                REG_SOURCE: cfg_reg.src  <= cfg_wdata[1:0];
                REG_SIZE:   cfg_reg.size <= cfg_wdata[1:0];
                REG_DISP:   cfg_reg.disp <= cfg_wdata[1:0];
                REG_CVAL:   cfg_reg.cval <= cfg_wdata;
                REG_N:      cfg_reg.pn   <= cfg_wdata;
                REG_X:      cfg_reg.px   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    mvsf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (v[0]),
        .out_item  (itm[0])
    );

    for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
        mvsf_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (v[i]),
            .in_item   (itm[i]),
            .out_valid (v[i+1]),
            .out_item  (itm[i+1])
        );
    end

    mvsf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (v[DIV_BITS]),
        .in_item   (itm[DIV_BITS]),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

[rtl/mvsf_checker.sv]
module mvsf_checker
    import mvsf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:49] == '0)
        else $error("result padding not zero");

endmodule

bind memory_value_search_filter mvsf_checker u_mvsf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
